// ===== rtl/aorr_pkg.sv =====
`default_nettype none

package aorr_pkg;

    localparam int OPCODE_W  = 2;
    localparam int TYPE_W    = 3;
    localparam int NUM_TYPES = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SELECT        = 2'd0,
        OP_MARK_ACTIVE   = 2'd1,
        OP_MARK_INACTIVE = 2'd2
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } aorr_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/aorr_ctrl.sv =====
`default_nettype none

module aorr_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire              m_ready,
    output aorr_pkg::aorr_cmd_t cmd
);
    import aorr_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    // take a new word only when the result slot is free by the next edge
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd          = '0;
        m_valid_next = m_valid_reg;
        case (state_reg)
            ST_IDLE: begin
                cmd.load = s_valid && s_ready;
                if (m_ready) begin
                    m_valid_next = 1'b0;
                end
            end
            ST_EXEC: begin
                cmd.exec     = 1'b1;
                m_valid_next = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_load_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_EXEC))
        else $error("accepted word did not enter execute");

    a_exec_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |-> !m_valid_reg)
        else $error("execute would overwrite a pending result");

    a_exec_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("execute did not produce a result");

endmodule

`default_nettype wire

// ===== rtl/aorr_dp.sv =====
`default_nettype none

module aorr_dp (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  aorr_pkg::aorr_cmd_t        cmd,
    input  wire [aorr_pkg::OPCODE_W-1:0] s_opcode,
    input  wire [aorr_pkg::TYPE_W-1:0]   s_queue_type,
    output logic                       m_grant_valid,
    output logic [aorr_pkg::TYPE_W-1:0]  m_granted_type,
    output logic                       m_any_active
);
    import aorr_pkg::*;

    localparam int CNT_W = $clog2(NUM_TYPES + 1);

    logic [OPCODE_W-1:0]  op_reg;
    logic [TYPE_W-1:0]    type_reg;
    logic [TYPE_W-1:0]    order_reg [NUM_TYPES];
    logic [TYPE_W-1:0]    order_next [NUM_TYPES];
    logic [TYPE_W-1:0]    shifted [NUM_TYPES];
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [NUM_TYPES-1:0] flags_reg, flags_next;
    logic [NUM_TYPES-1:0] hit;
    logic [NUM_TYPES-1:0] match;
    logic [NUM_TYPES-1:0] gap_before;
    logic                 is_active;
    logic                 grant_valid_next;
    logic [TYPE_W-1:0]    granted_next;
    logic                 grant_valid_reg;
    logic [TYPE_W-1:0]    granted_reg;
    logic                 any_active_reg;

    always_comb begin
        for (int i = 0; i < NUM_TYPES; i++) begin
            hit[i]   = (32'(type_reg) == i);
            match[i] = (order_reg[i] == type_reg) && (i < 32'(count_reg));
        end
        is_active = |(hit & flags_reg);
        // entry i closes the gap if the removed type sits at or before it
        for (int i = 0; i < NUM_TYPES; i++) begin
            gap_before[i] = 1'b0;
            for (int j = 0; j <= i; j++) begin
                gap_before[i] = gap_before[i] | match[j];
            end
        end
        for (int i = 0; i < NUM_TYPES - 1; i++) begin
            shifted[i] = order_reg[i + 1];
        end
        shifted[NUM_TYPES-1] = order_reg[NUM_TYPES-1];
    end

    always_comb begin
        order_next       = order_reg;
        count_next       = count_reg;
        flags_next       = flags_reg;
        grant_valid_next = 1'b0;
        granted_next     = '0;
        case (op_t'(op_reg))
            OP_SELECT: begin
                if (count_reg != '0) begin
                    grant_valid_next = 1'b1;
                    granted_next     = order_reg[0];
                    // rotate the head to the tail
                    for (int i = 0; i < NUM_TYPES; i++) begin
                        if (i + 1 < 32'(count_reg)) begin
                            order_next[i] = shifted[i];
                        end else if (i + 1 == 32'(count_reg)) begin
                            order_next[i] = order_reg[0];
                        end
                    end
                end
            end
            OP_MARK_ACTIVE: begin
                if ((|hit) && !is_active && (32'(count_reg) < NUM_TYPES)) begin
                    flags_next = flags_reg | hit;
                    count_next = count_reg + CNT_W'(1);
                    for (int i = 0; i < NUM_TYPES; i++) begin
                        if (i == 32'(count_reg)) begin
                            order_next[i] = type_reg;
                        end
                    end
                end
            end
            OP_MARK_INACTIVE: begin
                if (is_active) begin
                    flags_next = flags_reg & ~hit;
                    count_next = count_reg - CNT_W'(1);
                    for (int i = 0; i < NUM_TYPES; i++) begin
                        if (gap_before[i]) begin
                            order_next[i] = shifted[i];
                        end
                    end
                end
            end
            default: begin
                grant_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            flags_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_opcode;
            type_reg <= s_queue_type;
        end
        if (cmd.exec) begin
            order_reg       <= order_next;
            grant_valid_reg <= grant_valid_next;
            granted_reg     <= granted_next;
            any_active_reg  <= (count_next != '0);
        end
    end

    assign m_grant_valid  = grant_valid_reg;
    assign m_granted_type = granted_reg;
    assign m_any_active   = any_active_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= NUM_TYPES)
        else $error("active count exceeds number of types");

    a_count_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        32'($countones(flags_reg)) == 32'(count_reg))
        else $error("active count disagrees with active flags");

endmodule

`default_nettype wire

// ===== rtl/activation_order_round_robin.sv =====
// Round-robin arbiter over packet-type queues, served in activation order.
// Input channel (s_valid/s_ready): one word per command. s_opcode selects
// select-next, mark-active or mark-inactive; s_queue_type names the type for
// the mark commands. Result channel (m_valid/m_ready): exactly one word per
// command with m_grant_valid, m_granted_type and m_any_active.
// A word accepted at one edge is executed in the following cycle and its
// result is registered into the output register at the end of that cycle.
// The controller accepts a word only in its idle state, so no new word is
// taken while the previous one executes; the list update is done in the
// controller's execute state.
// The result sits in an output register, so a new word is taken in the same
// cycle the previous result is taken.
// Reset (aresetn low, synchronous): the active list is emptied and no
// result is pending. When the receiver stalls, the result is held and no
// further word is accepted until it is taken.
`default_nettype none

module activation_order_round_robin (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire [aorr_pkg::OPCODE_W-1:0] s_opcode,
    input  wire [aorr_pkg::TYPE_W-1:0]   s_queue_type,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic                         m_grant_valid,
    output logic [aorr_pkg::TYPE_W-1:0]  m_granted_type,
    output logic                         m_any_active
);
    import aorr_pkg::*;

    aorr_cmd_t cmd;

    aorr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    aorr_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_opcode       (s_opcode),
        .s_queue_type   (s_queue_type),
        .m_grant_valid  (m_grant_valid),
        .m_granted_type (m_granted_type),
        .m_any_active   (m_any_active)
    );

endmodule

`default_nettype wire
